// ===== rtl/cdq_pkg.sv =====
// Shared constants and types for the circular deque core.
// Used by cdq_ctrl, cdq_dpath and circular_deque_core; depends on nothing.
`default_nettype none

package cdq_pkg;

  localparam int unsigned DepthDefault     = 16;
  localparam int unsigned DataWidthDefault = 32;

  localparam int unsigned KindWidth   = 2;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CountWidth  = 5;

  // Operation codes carried in the input item's tuser.
  localparam logic [KindWidth-1:0] KindPushFront = 2'd0;
  localparam logic [KindWidth-1:0] KindPushBack  = 2'd1;
  localparam logic [KindWidth-1:0] KindPopFront  = 2'd2;
  localparam logic [KindWidth-1:0] KindPopBack   = 2'd3;

  // Result status codes.
  localparam logic [StatusWidth-1:0] StatusDone  = 2'd0;
  localparam logic [StatusWidth-1:0] StatusEmpty = 2'd1;
  localparam logic [StatusWidth-1:0] StatusFull  = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic exec;     // item accepted: update pointers, write or read slot
    logic capture;  // take the popped element from the read port
    logic load;     // move the result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free; // output register empty or drained this cycle
  } stat_t;

endpackage : cdq_pkg

`default_nettype wire

// ===== rtl/cdq_dpath.sv =====
// Datapath of the circular deque: slot memory, head/tail/fill pointers and
// the output register. Depends on cdq_pkg; steered by cdq_ctrl.
`default_nettype none

module cdq_dpath #(
  parameter int unsigned DEPTH      = cdq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DataWidthDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire cdq_pkg::cmd_t                      cmd_i,
  output cdq_pkg::stat_t                          stat_o,
  input  wire logic [cdq_pkg::KindWidth-1:0]      kind_i,
  input  wire logic [cdq_pkg::ValueWidth-1:0]     value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [cdq_pkg::ValueWidth-1:0]          popped_o,
  output logic [cdq_pkg::StatusWidth-1:0]         status_o,
  output logic [cdq_pkg::ValueWidth-1:0]          front_value_o,
  output logic [cdq_pkg::ValueWidth-1:0]          back_value_o,
  output logic [cdq_pkg::CountWidth-1:0]          count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [FW-1:0] FullCnt = FW'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          pop_ok_q, pop_ok_d;
  logic [cdq_pkg::StatusWidth-1:0] stat_q, stat_d;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr, rd_addr_a, pop_addr;
  logic [DATA_WIDTH-1:0] wr_data, rdata_a_q, rdata_b_q;
  logic [cdq_pkg::ValueWidth-1:0] popped_q;

  logic [AW-1:0] head_nx, head_pv, tail_nx, tail_pv;
  logic          is_push, at_front;

  assign head_nx  = (head_q == LastIdx) ? '0 : head_q + AW'(1);
  assign head_pv  = (head_q == '0) ? LastIdx : head_q - AW'(1);
  assign tail_nx  = (tail_q == LastIdx) ? '0 : tail_q + AW'(1);
  assign tail_pv  = (tail_q == '0) ? LastIdx : tail_q - AW'(1);
  assign is_push  = (kind_i == cdq_pkg::KindPushFront) || (kind_i == cdq_pkg::KindPushBack);
  assign at_front = (kind_i == cdq_pkg::KindPushFront) || (kind_i == cdq_pkg::KindPopFront);
  assign wr_data  = DATA_WIDTH'(value_i);
  assign pop_addr = at_front ? head_q : tail_q;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    pop_ok_d = pop_ok_q;
    stat_d   = stat_q;
    wr_en    = 1'b0;
    wr_addr  = '0;
    if (cmd_i.exec) begin
      pop_ok_d = 1'b0;
      stat_d   = cdq_pkg::StatusDone;
      if (is_push) begin
        if (fill_q == '0) begin
          head_d = '0;
          tail_d = '0;
          fill_d = FW'(1);
          wr_en  = 1'b1;
        end else if (fill_q == FullCnt) begin
          stat_d = cdq_pkg::StatusFull;
        end else begin
          wr_en  = 1'b1;
          fill_d = fill_q + FW'(1);
          if (at_front) begin
            head_d  = head_pv;
            wr_addr = head_pv;
          end else begin
            tail_d  = tail_nx;
            wr_addr = tail_nx;
          end
        end
      end else begin
        if (fill_q == '0) begin
          stat_d = cdq_pkg::StatusEmpty;
        end else begin
          pop_ok_d = 1'b1;
          fill_d   = fill_q - FW'(1);
          if (fill_q == FW'(1)) begin
            // last element gone: pointers return home
            head_d = '0;
            tail_d = '0;
          end else if (at_front) begin
            head_d = head_nx;
          end else begin
            tail_d = tail_pv;
          end
        end
      end
    end
  end

  // Port A reads the pop slot on the accept cycle, the front slot otherwise.
  assign rd_addr_a = cmd_i.exec ? pop_addr : head_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_a_q <= mem[rd_addr_a];
    rdata_b_q <= mem[tail_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      pop_ok_q    <= 1'b0;
      stat_q      <= cdq_pkg::StatusDone;
      out_valid_o <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      fill_q   <= fill_d;
      pop_ok_q <= pop_ok_d;
      stat_q   <= stat_d;
      if (cmd_i.load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      popped_q <= pop_ok_q ? cdq_pkg::ValueWidth'(rdata_a_q) : '0;
    end
    if (cmd_i.load) begin
      popped_o      <= popped_q;
      status_o      <= stat_q;
      front_value_o <= (fill_q != '0) ? cdq_pkg::ValueWidth'(rdata_a_q) : '0;
      back_value_o  <= (fill_q != '0) ? cdq_pkg::ValueWidth'(rdata_b_q) : '0;
      count_o       <= cdq_pkg::CountWidth'(fill_q);
    end
  end

  assign stat_o.out_free = !out_valid_o || out_ready_i;

endmodule : cdq_dpath

`default_nettype wire

// ===== rtl/cdq_ctrl.sv =====
// Sequencer of the circular deque: accept, capture, load.
// Depends on cdq_pkg; drives cdq_dpath through cmd_t.
`default_nettype none

module cdq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output cdq_pkg::cmd_t       cmd_o,
  input  wire cdq_pkg::stat_t stat_i
);

  typedef enum logic [1:0] {
    StIdle,
    StCapture,
    StLoad
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      in_ready_o <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            state_q    <= StCapture;
            in_ready_o <= 1'b0;
          end else begin
            in_ready_o <= 1'b1;
          end
        end
        StCapture: begin
          state_q <= StLoad;
        end
        StLoad: begin
          // hold until the output register can take the result
          if (stat_i.out_free) begin
            state_q    <= StIdle;
            in_ready_o <= 1'b1;
          end
        end
        default: begin
          state_q    <= StIdle;
          in_ready_o <= 1'b0;
        end
      endcase
    end
  end

  assign cmd_o.exec    = (state_q == StIdle) && in_valid_i && in_ready_o;
  assign cmd_o.capture = (state_q == StCapture);
  assign cmd_o.load    = (state_q == StLoad) && stat_i.out_free;

endmodule : cdq_ctrl

`default_nettype wire

// ===== rtl/circular_deque_core.sv =====
// Top level of the circular deque: stream ports around cdq_ctrl and cdq_dpath.
// Depends on cdq_pkg.
`default_nettype none

// Double-ended queue of DEPTH elements in a circular slot memory. Each input
// item (tuser = operation) gives one result item. The accepting edge updates
// the pointers and writes or reads the slot; in the capture state the popped
// element is captured while the new front and back slots are read; in the load
// state, once the output register is free, the result is loaded into it.
// The slot memory has one write port and two registered read ports. The next
// item is accepted in the cycle after the result is loaded, so the core takes
// no new item before the last one's result is loaded. A push on a full queue
// is refused with status 2, a pop on an empty queue returns zero with
// status 1. The slot memory needs no clearing.

module circular_deque_core #(
  parameter int unsigned DEPTH      = cdq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DataWidthDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // [31:0] value
  input  wire logic [1:0]   s_axis_tuser,   // [1:0] kind
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [103:0]      m_axis_tdata,   // [31:0] popped, [63:32] front_value,
                                            // [95:64] back_value, [100:96] count
  output logic [1:0]        m_axis_tuser    // [1:0] status
);

  cdq_pkg::cmd_t  cmd;
  cdq_pkg::stat_t stat;

  logic [cdq_pkg::ValueWidth-1:0] popped, front_value, back_value;
  logic [cdq_pkg::CountWidth-1:0] count;

  cdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  cdq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (s_axis_tuser),
    .value_i       (s_axis_tdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .popped_o      (popped),
    .status_o      (m_axis_tuser),
    .front_value_o (front_value),
    .back_value_o  (back_value),
    .count_o       (count)
  );

  assign m_axis_tdata = {3'b000, count, back_value, front_value, popped};

endmodule : circular_deque_core

`default_nettype wire
